>>> hw/rtl/sorted_priority_queue_macros.svh
// Assertion macros for the sorted priority queue.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/spq_pkg.sv
// Shared types, constants and functions of the sorted priority queue.
// No dependencies; the interfaces, top level, controller and datapath import this package.
package spq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int LEVEL_W      = 2;
  localparam int AGE_W        = 8;
  localparam int TAG_W        = 16;
  localparam int OCC_W        = 5;

  // Request kinds carried on the input channel.
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // One stored entry.
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [AGE_W-1:0]   age;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_t;

  // Store operation for the current cycle.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP
  } op_t;

  // Controller states: no result held, or a result waiting to be taken.
  typedef enum logic {
    CS_IDLE,
    CS_HOLD
  } ctrl_state_t;

  // Command from controller to datapath.
  typedef struct packed {
    op_t     op;
    logic    load;
    status_t status;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic full;
    logic empty;
  } dp_status_t;

  // True when entry a ranks ahead of entry b.
  function automatic logic outranks(entry_t a, entry_t b);
    logic res;
    if (a.level != b.level) begin
      res = (a.level > b.level);
    end else begin
      res = (a.age < b.age);
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/spq_if.sv
// Valid/ready channel interfaces for requests and results of the queue.
// Depends on spq_pkg for field widths.
interface spq_in_if;
  import spq_pkg::*;

  logic               valid;
  logic               ready;
  logic               kind;
  logic [LEVEL_W-1:0] priority_level;
  logic [AGE_W-1:0]   age;
  logic [TAG_W-1:0]   tag;

  modport source (output valid, kind, priority_level, age, tag, input ready);
  modport sink   (input valid, kind, priority_level, age, tag, output ready);
endinterface

interface spq_out_if;
  import spq_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [LEVEL_W-1:0] out_level;
  logic [AGE_W-1:0]   out_age;
  logic [TAG_W-1:0]   out_tag;
  logic [OCC_W-1:0]   occupancy;

  modport source (output valid, status, out_level, out_age, out_tag, occupancy,
                  input ready);
  modport sink   (input valid, status, out_level, out_age, out_tag, occupancy,
                  output ready);
endinterface

>>> hw/rtl/sorted_priority_queue.sv
// Sorted priority queue, top level. A result appears in the cycle after its
// request is accepted. It takes one push or pop request per cycle unless a
// held result stalls; set by the parallel compare and shift of the entry row.
// Reset clears the entry count and returns the controller to idle, so no
// result is valid; entry contents stay undefined until written and need no
// clearing pass.
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst_n,
  spq_in_if.sink     in_ch,
  spq_out_if.source  out_ch
);
  import spq_pkg::*;

  localparam logic [OCC_W-1:0] OCC_AT_FULL = OCC_W'(CAPACITY);

  cmd_t             cmd;
  dp_status_t       dp_status;
  entry_t           new_entry;
  status_t          res_status;
  entry_t           res_entry;
  logic [OCC_W-1:0] res_occupancy;
  logic             in_acc;

  // Incoming entry fields.
  assign new_entry.level = in_ch.priority_level;
  assign new_entry.age   = in_ch.age;
  assign new_entry.tag   = in_ch.tag;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.kind),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .new_entry     (new_entry),
    .dp_status     (dp_status),
    .res_status    (res_status),
    .res_entry     (res_entry),
    .res_occupancy (res_occupancy)
  );

  // Result channel payload.
  assign out_ch.status    = res_status;
  assign out_ch.out_level = res_entry.level;
  assign out_ch.out_age   = res_entry.age;
  assign out_ch.out_tag   = res_entry.tag;
  assign out_ch.occupancy = res_occupancy;

  assign in_acc = in_ch.valid && in_ch.ready;

  // A rejected push reports a full store.
  `SPQ_ASSERT_IMP(a_full_occ, out_ch.valid && out_ch.status == STS_FULL, out_ch.occupancy == OCC_AT_FULL, "full rejection with wrong occupancy")
  // A rejected pop reports an empty store.
  `SPQ_ASSERT_IMP(a_empty_occ, out_ch.valid && out_ch.status == STS_EMPTY, out_ch.occupancy == '0, "empty rejection with nonzero occupancy")
  // Rejected requests carry no entry.
  `SPQ_ASSERT_IMP(a_reject_zero, out_ch.valid && out_ch.status != STS_OK, out_ch.out_level == '0 && out_ch.out_age == '0 && out_ch.out_tag == '0, "rejected request carries entry data")
  // A push accepted on a full store yields a full rejection next cycle.
  `SPQ_ASSERT_NXT(a_push_full, in_acc && in_ch.kind == KIND_PUSH && dp_status.full, out_ch.valid && out_ch.status == STS_FULL, "push on full store not rejected")

endmodule

>>> hw/rtl/spq_ctrl.sv
// Controller of the sorted priority queue: request handshake, result holding
// and the choice of store operation. Depends on spq_pkg.
module spq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_kind,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  spq_pkg::dp_status_t dp_status,
  output spq_pkg::cmd_t      cmd
);
  import spq_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        accept;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A new request is taken whenever the result register is free or drains now.
  always_comb begin
    in_ready   = (state_r == CS_IDLE) || out_ready;
    out_valid  = (state_r == CS_HOLD);
    accept     = in_valid && in_ready;
    cmd.op     = OP_NONE;
    cmd.load   = accept;
    cmd.status = STS_OK;
    state_nxt  = state_r;

    // Pick the store operation, or reject it on a full or empty store.
    if (accept) begin
      if (in_kind == KIND_PUSH) begin
        if (dp_status.full) begin
          cmd.status = STS_FULL;
        end else begin
          cmd.op = OP_PUSH;
        end
      end else begin
        if (dp_status.empty) begin
          cmd.status = STS_EMPTY;
        end else begin
          cmd.op = OP_POP;
        end
      end
    end

    // Next state.
    case (state_r)
      CS_IDLE: begin
        if (accept) state_nxt = CS_HOLD;
      end
      CS_HOLD: begin
        if (accept) begin
          state_nxt = CS_HOLD;
        end else if (out_ready) begin
          state_nxt = CS_IDLE;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/spq_datapath.sv
// Datapath of the sorted priority queue: a row of entry cells that shift to
// insert or remove, the entry count and the result register. Depends on spq_pkg.
module spq_datapath #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  spq_pkg::cmd_t              cmd,
  input  spq_pkg::entry_t            new_entry,
  output spq_pkg::dp_status_t        dp_status,
  output spq_pkg::status_t           res_status,
  output spq_pkg::entry_t            res_entry,
  output logic [spq_pkg::OCC_W-1:0]  res_occupancy
);
  import spq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  entry_t          store_r [CAPACITY];
  logic [CW-1:0]   count_r, count_nxt;
  logic [CAPACITY-1:0] above;
  logic [CAPACITY-1:0] take_new;
  entry_t          from_prev [CAPACITY];
  entry_t          from_next [CAPACITY];
  logic [31:0]     count_wide;
  status_t         res_status_r;
  entry_t          res_entry_r;
  logic [OCC_W-1:0] res_occ_r;

  // Each cell compares its own entry with the incoming one; the set of
  // cells that outrank it is a prefix because the row is kept sorted.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign above[i] = (CW'(i) < count_r) && outranks(store_r[i], new_entry);
    if (i == 0) begin : g_head
      assign take_new[i]  = 1'b1;
      assign from_prev[i] = new_entry;
    end else begin : g_body
      assign take_new[i]  = above[i-1];
      assign from_prev[i] = store_r[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign from_next[i] = store_r[i];
    end else begin : g_inner
      assign from_next[i] = store_r[i+1];
    end
  end

  // Cell update: keep, take the new entry, shift down on push or up on pop.
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd.op == OP_PUSH) begin
        if (!above[i]) begin
          store_r[i] <= take_new[i] ? new_entry : from_prev[i];
        end
      end else if (cmd.op == OP_POP) begin
        store_r[i] <= from_next[i];
      end
    end
  end

  // Entry count.
  always_comb begin
    case (cmd.op)
      OP_PUSH: count_nxt = count_r + CW'(1);
      OP_POP:  count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign dp_status.full  = (count_r == CW'(CAPACITY));
  assign dp_status.empty = (count_r == '0);
  assign count_wide      = 32'(count_nxt);

  // Result register: the head entry on an accepted pop, zeros otherwise.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_status_r <= cmd.status;
      res_occ_r    <= count_wide[OCC_W-1:0];
      if (cmd.op == OP_POP) begin
        res_entry_r <= store_r[0];
      end else begin
        res_entry_r <= '0;
      end
    end
  end

  assign res_status    = res_status_r;
  assign res_entry     = res_entry_r;
  assign res_occupancy = res_occ_r;

endmodule
